// ===== rtl/pgw_pkg.sv =====
package pgw_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  // table pointer (40 bits) joined with a 9-bit index
  localparam int unsigned PTR_W     = 49;

  localparam int unsigned BIT_PRESENT   = 0;
  localparam int unsigned BIT_PAGE_SIZE = 7;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_READ      = 3'd1,
    OP_TRANSLATE = 3'd2,
    OP_MAP       = 3'd3,
    OP_UNMAP     = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [47:0] virtual_address;
    logic [11:0] word_index;
    logic [63:0] data_value;
    logic [63:0] page_flags;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] physical_address;
    logic [63:0] read_data;
  } rsp_t;

  // microprogram steps
  typedef enum logic [3:0] {
    U_CLEAR   = 4'd0,
    U_IDLE    = 4'd1,
    U_RAWWR   = 4'd2,
    U_RAWRD   = 4'd3,
    U_RAWDATA = 4'd4,
    U_L0      = 4'd5,
    U_L1      = 4'd6,
    U_L2      = 4'd7,
    U_PDT     = 4'd8,
    U_LEAF    = 4'd9,
    U_PDW     = 4'd10,
    U_NOP     = 4'd11
  } upc_e;

  typedef enum logic [1:0] {
    JC_NONE,
    JC_DISPATCH,
    JC_CLEAR,
    JC_TRANSLATE
  } jc_e;

  typedef enum logic [1:0] {
    SUP_IGNORE,
    SUP_PASS,
    SUP_REFUSE
  } sup_e;

  typedef enum logic [1:0] {
    AS_ROOT,
    AS_ENTRY,
    AS_RAW
  } asel_e;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_READ,
    MOP_WRITE_RAW,
    MOP_WRITE_LEAF,
    MOP_CLEAR
  } mop_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_RAW,
    RES_LEAF
  } res_e;

  typedef struct packed {
    upc_e       next;
    upc_e       alt;
    jc_e        jc;
    logic       chk_present;
    sup_e       sup;
    asel_e      asel;
    logic [1:0] lvl;
    mop_e       mop;
    logic       fin;
    res_e       rsel;
  } uword_t;

  function automatic uword_t ucode(upc_e pc);
    uword_t w;
    w = '0;
    w.next = U_IDLE;
    w.alt  = U_IDLE;
    w.jc   = JC_NONE;
    w.sup  = SUP_IGNORE;
    w.asel = AS_RAW;
    w.mop  = MOP_NONE;
    w.rsel = RES_NONE;
    unique case (pc)
      U_CLEAR: begin
        w.jc   = JC_CLEAR;
        w.alt  = U_CLEAR;
        w.mop  = MOP_CLEAR;
      end
      U_IDLE: begin
        w.jc   = JC_DISPATCH;
      end
      U_RAWWR: begin
        w.asel = AS_RAW;
        w.mop  = MOP_WRITE_RAW;
        w.fin  = 1'b1;
      end
      U_RAWRD: begin
        w.asel = AS_RAW;
        w.mop  = MOP_READ;
        w.next = U_RAWDATA;
      end
      U_RAWDATA: begin
        w.fin  = 1'b1;
        w.rsel = RES_RAW;
      end
      U_L0: begin
        w.asel = AS_ROOT;
        w.lvl  = 2'd0;
        w.mop  = MOP_READ;
        w.next = U_L1;
      end
      U_L1: begin
        w.chk_present = 1'b1;
        w.asel = AS_ENTRY;
        w.lvl  = 2'd1;
        w.mop  = MOP_READ;
        w.next = U_L2;
      end
      U_L2: begin
        w.chk_present = 1'b1;
        w.asel = AS_ENTRY;
        w.lvl  = 2'd2;
        w.mop  = MOP_READ;
        w.jc   = JC_TRANSLATE;
        w.alt  = U_PDT;
        w.next = U_PDW;
      end
      U_PDT: begin
        w.chk_present = 1'b1;
        w.sup  = SUP_PASS;
        w.asel = AS_ENTRY;
        w.lvl  = 2'd3;
        w.mop  = MOP_READ;
        w.next = U_LEAF;
      end
      U_LEAF: begin
        w.chk_present = 1'b1;
        w.fin  = 1'b1;
        w.rsel = RES_LEAF;
      end
      U_PDW: begin
        w.chk_present = 1'b1;
        w.sup  = SUP_REFUSE;
        w.asel = AS_ENTRY;
        w.lvl  = 2'd3;
        w.mop  = MOP_WRITE_LEAF;
        w.fin  = 1'b1;
      end
      U_NOP: begin
        w.fin  = 1'b1;
      end
      default: begin
        w.next = U_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic upc_e dispatch(logic [2:0] op);
    upc_e pc;
    unique case (op)
      OP_WRITE:     pc = U_RAWWR;
      OP_READ:      pc = U_RAWRD;
      OP_TRANSLATE: pc = U_L0;
      OP_MAP:       pc = U_L0;
      OP_UNMAP:     pc = U_L0;
      default:      pc = U_NOP;
    endcase
    return pc;
  endfunction

endpackage

// ===== rtl/four_level_page_table_walker.sv =====
// Steps: raw write writes, unused opcodes do nothing, raw read reads then returns data;
//   map/unmap read levels 0-2, write the leaf; translate reads 0-3, or 0-2 for a superpage;
//   a missing level or a pointer out of range ends the walk early, at the failing level.
// Throughput: busy_o drops in the cycle the result shows, so the next request can be taken
//   then; the pace is one table read per walk level on the single memory port.
// Reset: the sequencer sweeps all MEM_WORDS words of the memory to zero, one word a cycle,
//   with busy_o high; results are strobed for one cycle and cannot be stalled.
module four_level_page_table_walker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  pgw_pkg::req_t req_i,
  output logic          done_o,
  output pgw_pkg::rsp_t result_o,
  input  logic          cfg_we_i,
  input  logic [14:0]   cfg_data_i
);

  pgw_pkg::upc_e  upc_q, upc_d;
  pgw_pkg::uword_t uw;
  pgw_pkg::req_t  req_q;
  pgw_pkg::rsp_t  res_q, res_d;
  logic           done_q, done_d;
  logic [2:0]     root_q;
  logic [pgw_pkg::MEM_AW-1:0] clr_q, clr_d;

  logic [63:0] mem_q [pgw_pkg::MEM_WORDS];
  logic [63:0] rd_q;

  logic [8:0]               idx;
  logic [pgw_pkg::PTR_W-1:0] ptr;
  logic                     in_range;
  logic                     addr_op;
  logic                     mem_re, mem_we;
  logic [pgw_pkg::MEM_AW-1:0] mem_waddr;
  logic [63:0]              mem_wdata;
  logic                     accept;

  assign accept = start_i && !busy_o;
  assign busy_o = (upc_q != pgw_pkg::U_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  assign uw = pgw_pkg::ucode(upc_q);

  always_comb begin
    unique case (uw.lvl)
      2'd0:    idx = req_q.virtual_address[47:39];
      2'd1:    idx = req_q.virtual_address[38:30];
      2'd2:    idx = req_q.virtual_address[29:21];
      default: idx = req_q.virtual_address[20:12];
    endcase
  end

  // word pointer = (table byte address / 8) + index
  always_comb begin
    unique case (uw.asel)
      pgw_pkg::AS_ROOT:  ptr = {37'd0, root_q, idx};
      pgw_pkg::AS_ENTRY: ptr = {rd_q[51:12], idx};
      default:           ptr = {37'd0, req_q.word_index};
    endcase
  end

  assign in_range = (ptr < pgw_pkg::PTR_W'(pgw_pkg::MEM_WORDS));
  assign addr_op  = (uw.mop == pgw_pkg::MOP_READ) || (uw.mop == pgw_pkg::MOP_WRITE_RAW) ||
                    (uw.mop == pgw_pkg::MOP_WRITE_LEAF);

  always_comb begin
    upc_d  = upc_q;
    clr_d  = clr_q;
    done_d = 1'b0;
    res_d  = '0;
    res_d.status = pgw_pkg::ST_DONE;
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_waddr = ptr[pgw_pkg::MEM_AW-1:0];
    mem_wdata = req_q.data_value;

    if (uw.mop == pgw_pkg::MOP_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
      clr_d     = clr_q + 1'b1;
    end

    if (upc_q != pgw_pkg::U_IDLE && upc_q != pgw_pkg::U_CLEAR) begin
      priority if (uw.chk_present && !rd_q[pgw_pkg::BIT_PRESENT]) begin
        done_d = 1'b1;
        res_d.status = pgw_pkg::ST_ABSENT;
      end else if (uw.sup == pgw_pkg::SUP_PASS && rd_q[pgw_pkg::BIT_PAGE_SIZE]) begin
        done_d = 1'b1;
        res_d.physical_address = {12'd0, rd_q[51:21], req_q.virtual_address[20:0]};
      end else if (uw.sup == pgw_pkg::SUP_REFUSE && rd_q[pgw_pkg::BIT_PAGE_SIZE]) begin
        done_d = 1'b1;
        res_d.status = pgw_pkg::ST_ABSENT;
      end else if (addr_op && !in_range) begin
        done_d = 1'b1;
        res_d.status = pgw_pkg::ST_RANGE;
      end else begin
        unique case (uw.mop)
          pgw_pkg::MOP_READ:      mem_re = 1'b1;
          pgw_pkg::MOP_WRITE_RAW: mem_we = 1'b1;
          pgw_pkg::MOP_WRITE_LEAF: begin
            mem_we = 1'b1;
            mem_wdata = (req_q.opcode == pgw_pkg::OP_MAP) ?
                        ((req_q.data_value & 64'h000F_FFFF_FFFF_F000) | req_q.page_flags |
                         64'd1) : 64'd0;
          end
          default: ;
        endcase
        if (uw.fin) begin
          done_d = 1'b1;
          unique case (uw.rsel)
            pgw_pkg::RES_RAW:  res_d.read_data = rd_q;
            pgw_pkg::RES_LEAF: res_d.physical_address =
                                 {12'd0, rd_q[51:12], req_q.virtual_address[11:0]};
            default: ;
          endcase
        end
      end
    end

    // sequencing
    if (done_d) begin
      upc_d = pgw_pkg::U_IDLE;
    end else begin
      unique case (uw.jc)
        pgw_pkg::JC_DISPATCH: begin
          if (accept) upc_d = pgw_pkg::dispatch(req_i.opcode);
        end
        pgw_pkg::JC_CLEAR: begin
          upc_d = (clr_q == pgw_pkg::MEM_AW'(pgw_pkg::MEM_WORDS - 1)) ? uw.next : uw.alt;
        end
        pgw_pkg::JC_TRANSLATE: begin
          upc_d = (req_q.opcode == pgw_pkg::OP_TRANSLATE) ? uw.alt : uw.next;
        end
        default: upc_d = uw.next;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q  <= pgw_pkg::U_CLEAR;
      clr_q  <= '0;
      done_q <= 1'b0;
      root_q <= '0;
    end else begin
      upc_q  <= upc_d;
      clr_q  <= clr_d;
      done_q <= done_d;
      if (cfg_we_i) root_q <= cfg_data_i[14:12];
    end
  end

  // payload: hold the request, latch the result beat
  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    if (done_d) res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[ptr[pgw_pkg::MEM_AW-1:0]];
  end

  a_no_result_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !done_o) else $error("result right after accept");

  a_idle_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result while still walking");

  a_result_follows_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without a finishing step");

  a_fault_zero_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != pgw_pkg::ST_DONE) |->
      (result_o.physical_address == 64'd0 && result_o.read_data == 64'd0))
    else $error("faulting result carries data");

endmodule
